[design/dll_pkg.sv]
// shared types and constants for the linked list cursor engine
`timescale 1ns / 1ps
package dll_pkg;
	localparam int NodeCountDef  = 16;
	localparam int ValueWidthDef = 32;

	typedef enum logic [4:0] {
		OP_CLEAR      = 5'd0,
		OP_INS_FIRST  = 5'd1,
		OP_INS_LAST   = 5'd2,
		OP_GO_FIRST   = 5'd3,
		OP_GO_LAST    = 5'd4,
		OP_RD_FIRST   = 5'd5,
		OP_RD_LAST    = 5'd6,
		OP_DEL_FIRST  = 5'd7,
		OP_DEL_LAST   = 5'd8,
		OP_DEL_AFTER  = 5'd9,
		OP_DEL_BEFORE = 5'd10,
		OP_INS_AFTER  = 5'd11,
		OP_INS_BEFORE = 5'd12,
		OP_RD_ACTIVE  = 5'd13,
		OP_WR_ACTIVE  = 5'd14,
		OP_NEXT       = 5'd15,
		OP_PREV       = 5'd16,
		OP_QUERY      = 5'd17
	} op_t;

	typedef struct packed {
		logic [4:0]         operation;
		logic signed [31:0] value_in;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               error;
		logic               active;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RD1,
		ST_RD2,
		ST_WR,
		ST_DONE
	} state_t;
endpackage

[design/dll_alloc.sv]
// free node search: scans the allocation bitmap one node per cycle
`timescale 1ns / 1ps
module dll_alloc import dll_pkg::*; #(
	parameter int NODE_COUNT = NodeCountDef,
	localparam int AW = $clog2(NODE_COUNT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NODE_COUNT-1:0] used,
	output logic                  done,
	output logic                  found,
	output logic [AW-1:0]         slot
);
	logic [AW-1:0] idx_q;
	logic          busy_q;
	logic          hit;
	logic          last;

	assign hit  = busy_q && !used[idx_q[$clog2(NODE_COUNT)-1:0]];
	assign last = idx_q == AW'(NODE_COUNT - 1);
	assign done = busy_q && (hit || last);
	assign found = hit;
	assign slot = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			if (hit || last) busy_q <= 1'b0;
			else idx_q <= idx_q + 1'b1;
		end
	end
endmodule

[design/doubly_linked_list_cursor.sv]
// top level of the linked list cursor engine
// Doubly linked list over a pool of NODE_COUNT nodes with head, tail and cursor.
// cmd channel: one beat carries operation and value_in; rsp channel returns one
// beat per command with read_value, error and active.
// One command at a time: cmd_stall is high from acceptance until the response
// beat leaves. Commands walk one sequencer: a search step, two node table
// reads and four write slots on the shared table port, then a done state that
// loads the response register. Inserts stretch the search to one cycle per
// bitmap bit scanned up to the free slot; an insert into a full pool skips the
// reads and writes and goes from the search straight to the done state.
// The response sits in an output register; while rsp_stall is high it holds
// and no new command is taken.
// Reset clears the bitmap and nulls head, tail and cursor; node
// contents stay undefined until written and nothing reaches them.
`timescale 1ns / 1ps
module doubly_linked_list_cursor import dll_pkg::*; #(
	parameter int NODE_COUNT  = NodeCountDef,
	parameter int VALUE_WIDTH = ValueWidthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);
	localparam int AW = $clog2(NODE_COUNT + 1);
	localparam int IW = $clog2(NODE_COUNT);
	localparam logic [AW-1:0] NIL = AW'(NODE_COUNT);

	// node table: links written per field
	logic [VALUE_WIDTH-1:0] val_mem [NODE_COUNT];
	logic [AW-1:0]          lft_mem [NODE_COUNT];
	logic [AW-1:0]          rgt_mem [NODE_COUNT];

	state_t state_q, state_d;
	logic [NODE_COUNT-1:0] used_q;
	logic [AW-1:0] head_q, tail_q, cur_q;
	logic [4:0]    op_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic [AW-1:0] n_q;     // new or removed node
	logic [AW-1:0] a_q;     // first link read
	logic [AW-1:0] b_q;     // second link read
	logic [VALUE_WIDTH-1:0] rdv_q;
	logic          err_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic [1:0]    wstep_q;

	logic al_start, al_done, al_found;
	logic [AW-1:0] al_slot;

	dll_alloc #(.NODE_COUNT(NODE_COUNT)) u_alloc (
		.clk(clk), .arst_n(arst_n), .start(al_start), .used(used_q),
		.done(al_done), .found(al_found), .slot(al_slot)
	);

	function automatic logic isn(logic [AW-1:0] p);
		return p < NIL;
	endfunction

	logic is_ins;
	assign is_ins = op_q == OP_INS_FIRST || op_q == OP_INS_LAST ||
		((op_q == OP_INS_AFTER || op_q == OP_INS_BEFORE) && isn(cur_q));

	assign cmd_stall = state_q != ST_IDLE || rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign al_start = state_q == ST_IDLE && cmd_valid && !cmd_stall &&
		(cmd.operation == OP_INS_FIRST || cmd.operation == OP_INS_LAST ||
		((cmd.operation == OP_INS_AFTER || cmd.operation == OP_INS_BEFORE) && isn(cur_q)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd_valid && !cmd_stall) state_d = ST_SEARCH;
			ST_SEARCH: begin
				if (!is_ins) state_d = ST_RD1;
				else if (al_done) state_d = al_found ? ST_RD1 : ST_DONE;
			end
			ST_RD1:    state_d = ST_RD2;
			ST_RD2:    state_d = ST_WR;
			ST_WR:     if (wstep_q == 2'd3) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// link read addresses for the RD1 and RD2 reads
	logic [AW-1:0] ra;
	logic [IW-1:0] ri;
	always_comb begin
		ra = NIL;
		case (op_q)
			OP_DEL_FIRST: ra = head_q;
			OP_DEL_LAST:  ra = tail_q;
			OP_DEL_AFTER:  ra = (state_q == ST_RD1) ? cur_q : b_q;
			OP_DEL_BEFORE: ra = (state_q == ST_RD1) ? cur_q : a_q;
			OP_INS_AFTER, OP_INS_BEFORE, OP_RD_ACTIVE, OP_NEXT, OP_PREV: ra = cur_q;
			OP_RD_FIRST:  ra = head_q;
			OP_RD_LAST:   ra = tail_q;
			default:      ra = NIL;
		endcase
		ri = ra[IW-1:0];
	end

	// link writes: up to four, one per cycle
	logic          we;
	logic [AW-1:0] wa;
	logic          wl;  // 1 writes left link, 0 right link
	logic [AW-1:0] wd;
	logic          wval;
	always_comb begin
		we = 1'b0; wa = NIL; wl = 1'b0; wd = NIL; wval = 1'b0;
		if (state_q == ST_WR) begin
			case (op_q)
				OP_INS_FIRST: case (wstep_q)
					2'd0: begin we = 1'b1; wa = n_q; wl = 1'b1; wd = NIL; wval = 1'b1; end
					2'd1: begin we = 1'b1; wa = n_q; wl = 1'b0; wd = head_q; end
					2'd2: begin we = isn(head_q); wa = head_q; wl = 1'b1; wd = n_q; end
					default: ;
				endcase
				OP_INS_LAST: case (wstep_q)
					2'd0: begin we = 1'b1; wa = n_q; wl = 1'b0; wd = NIL; wval = 1'b1; end
					2'd1: begin we = 1'b1; wa = n_q; wl = 1'b1; wd = tail_q; end
					2'd2: begin we = isn(head_q) && isn(tail_q); wa = tail_q; wl = 1'b0;
						wd = n_q; end
					default: ;
				endcase
				OP_INS_AFTER: if (isn(cur_q)) begin
					case (wstep_q)
						2'd0: begin we = 1'b1; wa = n_q; wl = 1'b0; wd = b_q; wval = 1'b1; end
						2'd1: begin we = 1'b1; wa = n_q; wl = 1'b1; wd = cur_q; end
						2'd2: begin we = 1'b1; wa = cur_q; wl = 1'b0; wd = n_q; end
						default: begin we = cur_q != tail_q; wa = b_q; wl = 1'b1; wd = n_q; end
					endcase
				end
				OP_INS_BEFORE: if (isn(cur_q)) begin
					case (wstep_q)
						2'd0: begin we = 1'b1; wa = n_q; wl = 1'b1; wd = a_q; wval = 1'b1; end
						2'd1: begin we = 1'b1; wa = n_q; wl = 1'b0; wd = cur_q; end
						2'd2: begin we = 1'b1; wa = cur_q; wl = 1'b1; wd = n_q; end
						default: begin we = cur_q != head_q; wa = a_q; wl = 1'b0; wd = n_q; end
					endcase
				end
				OP_DEL_FIRST: if (wstep_q == 2'd0 && head_q != tail_q) begin
					we = isn(b_q); wa = b_q; wl = 1'b1; wd = NIL; end
				OP_DEL_LAST: if (wstep_q == 2'd0 && head_q != tail_q) begin
					we = isn(a_q); wa = a_q; wl = 1'b0; wd = NIL; end
				OP_DEL_AFTER: if (n_q != NIL) begin
					if (wstep_q == 2'd0) begin we = 1'b1; wa = cur_q; wl = 1'b0; wd = b_q; end
					else if (wstep_q == 2'd1 && n_q != tail_q) begin
						we = isn(b_q); wa = b_q; wl = 1'b1; wd = cur_q; end
				end
				OP_DEL_BEFORE: if (n_q != NIL) begin
					if (wstep_q == 2'd0) begin we = 1'b1; wa = cur_q; wl = 1'b1; wd = a_q; end
					else if (wstep_q == 2'd1 && n_q != head_q) begin
						we = isn(a_q); wa = a_q; wl = 1'b0; wd = cur_q; end
				end
				OP_WR_ACTIVE: if (wstep_q == 2'd0 && isn(cur_q)) begin
					wa = cur_q; wval = 1'b1; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we && isn(wa)) begin
			if (wl) lft_mem[wa[IW-1:0]] <= wd;
			else    rgt_mem[wa[IW-1:0]] <= wd;
		end
		if (wval && isn(wa)) val_mem[wa[IW-1:0]] <= v_q;
	end

	// command, free slot and read cycle captures
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && !cmd_stall) begin
			op_q <= cmd.operation;
			v_q  <= VALUE_WIDTH'(cmd.value_in);
		end
		if (state_q == ST_SEARCH && is_ins && al_done) n_q <= al_slot;
		if (state_q == ST_RD1) begin
			a_q   <= isn(ra) ? lft_mem[ri] : NIL;
			b_q   <= isn(ra) ? rgt_mem[ri] : NIL;
			rdv_q <= isn(ra) ? val_mem[ri] : '0;
			if (op_q == OP_DEL_FIRST) n_q <= head_q;
			if (op_q == OP_DEL_LAST)  n_q <= tail_q;
		end
		if (state_q == ST_RD2) begin
			// cursor deletes: removed node and its far neighbor
			if (op_q == OP_DEL_AFTER) begin
				n_q <= (isn(cur_q) && cur_q != tail_q && isn(head_q) && isn(b_q)) ? b_q : NIL;
				b_q <= isn(ra) ? rgt_mem[ri] : NIL;
			end
			if (op_q == OP_DEL_BEFORE) begin
				n_q <= (isn(cur_q) && cur_q != head_q && isn(head_q) && isn(a_q)) ? a_q : NIL;
				a_q <= isn(ra) ? lft_mem[ri] : NIL;
			end
		end
	end

	// pointers, bitmap and response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			head_q  <= NIL;
			tail_q  <= NIL;
			cur_q   <= NIL;
			wstep_q <= '0;
			err_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q   <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			if (state_q == ST_IDLE && cmd_valid && !cmd_stall) begin
				err_q <= 1'b0;
				wstep_q <= '0;
				if (!isn(head_q) || !isn(tail_q)) begin head_q <= NIL; tail_q <= NIL; end
			end
			if (state_q == ST_SEARCH && is_ins && al_done) begin
				if (al_found) used_q[al_slot[IW-1:0]] <= 1'b1;
				else err_q <= 1'b1;
			end
			if (state_q == ST_WR) wstep_q <= wstep_q + 2'd1;
			if (state_q == ST_WR && wstep_q == 2'd3) begin
				unique case (op_q)
					OP_CLEAR: begin
						used_q <= '0; head_q <= NIL; tail_q <= NIL; cur_q <= NIL;
					end
					OP_INS_FIRST: if (!err_q) begin
						if (!isn(head_q)) tail_q <= n_q;
						head_q <= n_q;
					end
					OP_INS_LAST: if (!err_q) begin
						if (!isn(head_q)) head_q <= n_q;
						tail_q <= n_q;
					end
					OP_INS_AFTER: if (!err_q && isn(cur_q) && cur_q == tail_q) tail_q <= n_q;
					OP_INS_BEFORE: if (!err_q && isn(cur_q) && cur_q == head_q) head_q <= n_q;
					OP_GO_FIRST: cur_q <= head_q;
					OP_GO_LAST:  cur_q <= tail_q;
					OP_RD_FIRST, OP_RD_LAST: err_q <= !isn(ra);
					OP_RD_ACTIVE: err_q <= !isn(cur_q);
					OP_DEL_FIRST: if (isn(head_q)) begin
						if (n_q == cur_q) cur_q <= NIL;
						if (head_q != tail_q) begin
							head_q <= b_q;
							if (!isn(b_q)) tail_q <= NIL;
						end else begin
							head_q <= NIL; tail_q <= NIL;
						end
						used_q[n_q[IW-1:0]] <= 1'b0;
					end
					OP_DEL_LAST: if (isn(tail_q)) begin
						if (n_q == cur_q) cur_q <= NIL;
						if (head_q != tail_q) begin
							tail_q <= a_q;
							if (!isn(a_q)) head_q <= NIL;
						end else begin
							head_q <= NIL; tail_q <= NIL;
						end
						used_q[n_q[IW-1:0]] <= 1'b0;
					end
					OP_DEL_AFTER: if (isn(n_q)) begin
						if (n_q == tail_q) tail_q <= cur_q;
						used_q[n_q[IW-1:0]] <= 1'b0;
					end
					OP_DEL_BEFORE: if (isn(n_q)) begin
						if (n_q == head_q) head_q <= cur_q;
						used_q[n_q[IW-1:0]] <= 1'b0;
					end
					OP_NEXT: if (isn(cur_q)) cur_q <= isn(b_q) ? b_q : NIL;
					OP_PREV: if (isn(cur_q)) cur_q <= isn(a_q) ? a_q : NIL;
					default: ;
				endcase
			end
			if (state_q == ST_DONE) begin
				rsp_valid_q <= 1'b1;
				rsp_q.error <= err_q;
				rsp_q.active <= isn(cur_q);
				rsp_q.read_value <= (!err_q && (op_q == OP_RD_FIRST || op_q == OP_RD_LAST ||
						op_q == OP_RD_ACTIVE)) ? 32'(signed'(rdv_q)) : '0;
			end
		end
	end
endmodule

[sim/doubly_linked_list_cursor_tb.sv]
// testbench for the linked list cursor engine: directed table plus random command mix
`timescale 1ns / 1ps
module doubly_linked_list_cursor_tb;
	import dll_pkg::*;

	localparam int NODES = 16;
	localparam int NIL = NODES;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	doubly_linked_list_cursor dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// list mirror
	logic [31:0] mir_val [NODES];
	int          mir_left [NODES];
	int          mir_right [NODES];
	logic        mir_used [NODES];
	int          mir_head, mir_tail, mir_cur;

	rsp_t  pending_rsp [$];
	logic  row_known [$];
	rsp_t  row_rsp [$];
	int    fail_count;
	int    quiet_cycles;
	int    send_idle_pct, recv_stall_pct;
	logic  hold_rsp;
	logic  done_send;

	function automatic int list_len();
		int c;
		c = 0;
		for (int i = 0; i < NODES; i++) if (mir_used[i]) c++;
		return c;
	endfunction

	function automatic int grab_node(logic [31:0] v);
		for (int i = 0; i < NODES; i++) begin
			if (!mir_used[i]) begin
				mir_used[i] = 1'b1;
				mir_val[i] = v;
				return i;
			end
		end
		return NIL;
	endfunction

	function automatic rsp_t apply_cmd(cmd_t c);
		rsp_t r;
		int n, it;
		r = '0;
		case (c.operation)
			OP_CLEAR: begin
				for (int i = 0; i < NODES; i++) mir_used[i] = 1'b0;
				mir_head = NIL; mir_tail = NIL; mir_cur = NIL;
			end
			OP_INS_FIRST: begin
				n = grab_node(c.value_in);
				if (n == NIL) r.error = 1'b1;
				else begin
					mir_left[n] = NIL; mir_right[n] = mir_head;
					if (mir_head == NIL) mir_tail = n;
					else mir_left[mir_head] = n;
					mir_head = n;
				end
			end
			OP_INS_LAST: begin
				n = grab_node(c.value_in);
				if (n == NIL) r.error = 1'b1;
				else begin
					mir_right[n] = NIL; mir_left[n] = mir_tail;
					if (mir_head == NIL) mir_head = n;
					else mir_right[mir_tail] = n;
					mir_tail = n;
				end
			end
			OP_GO_FIRST: mir_cur = mir_head;
			OP_GO_LAST: mir_cur = mir_tail;
			OP_RD_FIRST: begin
				if (mir_head == NIL) r.error = 1'b1;
				else r.read_value = mir_val[mir_head];
			end
			OP_RD_LAST: begin
				if (mir_tail == NIL) r.error = 1'b1;
				else r.read_value = mir_val[mir_tail];
			end
			OP_DEL_FIRST: begin
				if (mir_head != NIL) begin
					it = mir_head;
					if (it == mir_cur) mir_cur = NIL;
					if (mir_head != mir_tail) begin
						mir_head = mir_right[it];
						mir_left[mir_head] = NIL;
					end else begin
						mir_head = NIL; mir_tail = NIL;
					end
					mir_used[it] = 1'b0;
				end
			end
			OP_DEL_LAST: begin
				if (mir_tail != NIL) begin
					it = mir_tail;
					if (it == mir_cur) mir_cur = NIL;
					if (mir_head != mir_tail) begin
						mir_tail = mir_left[it];
						mir_right[mir_tail] = NIL;
					end else begin
						mir_head = NIL; mir_tail = NIL;
					end
					mir_used[it] = 1'b0;
				end
			end
			OP_DEL_AFTER: begin
				if (mir_cur != NIL && mir_cur != mir_tail) begin
					it = mir_right[mir_cur];
					mir_right[mir_cur] = mir_right[it];
					if (it == mir_tail) mir_tail = mir_cur;
					else mir_left[mir_right[it]] = mir_cur;
					mir_used[it] = 1'b0;
				end
			end
			OP_DEL_BEFORE: begin
				if (mir_cur != NIL && mir_cur != mir_head) begin
					it = mir_left[mir_cur];
					mir_left[mir_cur] = mir_left[it];
					if (it == mir_head) mir_head = mir_cur;
					else mir_right[mir_left[it]] = mir_cur;
					mir_used[it] = 1'b0;
				end
			end
			OP_INS_AFTER: begin
				if (mir_cur != NIL) begin
					n = grab_node(c.value_in);
					if (n == NIL) r.error = 1'b1;
					else begin
						mir_right[n] = mir_right[mir_cur];
						mir_left[n] = mir_cur;
						mir_right[mir_cur] = n;
						if (mir_cur != mir_tail) mir_left[mir_right[n]] = n;
						else mir_tail = n;
					end
				end
			end
			OP_INS_BEFORE: begin
				if (mir_cur != NIL) begin
					n = grab_node(c.value_in);
					if (n == NIL) r.error = 1'b1;
					else begin
						mir_left[n] = mir_left[mir_cur];
						mir_right[n] = mir_cur;
						mir_left[mir_cur] = n;
						if (mir_cur != mir_head) mir_right[mir_left[n]] = n;
						else mir_head = n;
					end
				end
			end
			OP_RD_ACTIVE: begin
				if (mir_cur == NIL) r.error = 1'b1;
				else r.read_value = mir_val[mir_cur];
			end
			OP_WR_ACTIVE: if (mir_cur != NIL) mir_val[mir_cur] = c.value_in;
			OP_NEXT: if (mir_cur != NIL) mir_cur = mir_right[mir_cur];
			OP_PREV: if (mir_cur != NIL) mir_cur = mir_left[mir_cur];
			default: ;
		endcase
		r.active = (mir_cur != NIL);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		fail_count++;
	endtask

	// directed rows: op, value, whether result is typed in, result
	typedef struct {
		op_t         op;
		logic [31:0] val;
		logic        known;
		rsp_t        res;
	} row_t;

	row_t rows [$];

	function automatic void add_row(op_t o, logic [31:0] v, logic k = 0, rsp_t r = '0);
		row_t x;
		x.op = o; x.val = v; x.known = k; x.res = r;
		rows.push_back(x);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// response checking
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected beat", 64'($unsigned(rsp.read_value)), 64'(0));
			end else begin
				rsp_t w;
				logic k;
				rsp_t tr;
				w = pending_rsp.pop_front();
				k = row_known.pop_front();
				tr = row_rsp.pop_front();
				if (k && tr != w) report_mismatch("typed row vs predictor", 64'(tr), 64'(w));
				if (rsp.read_value !== w.read_value)
					report_mismatch("read_value", 64'($unsigned(rsp.read_value)),
						64'($unsigned(w.read_value)));
				if (rsp.error !== w.error)
					report_mismatch("error", 64'(rsp.error), 64'(w.error));
				if (rsp.active !== w.active)
					report_mismatch("active", 64'(rsp.active), 64'(w.active));
			end
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (!arst_n) rsp_stall <= 1'b0;
		else rsp_stall <= hold_rsp || ($urandom_range(99, 0) < recv_stall_pct);
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || !arst_n)
			quiet_cycles <= 0;
		else if (!done_send || pending_rsp.size() != 0)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin
		hold_rsp = 1'b0;
		wait (arst_n);
		repeat (200) @(posedge clk);
		hold_rsp <= 1'b1;
		repeat (300) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	task automatic send_beat(op_t o, logic [31:0] v, logic k, rsp_t r);
		cmd_t c;
		// valid drops between beats
		@(posedge clk);
		while ($urandom_range(99, 0) < send_idle_pct) @(posedge clk);
		c.operation = o;
		c.value_in = v;
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		pending_rsp.push_back(apply_cmd(c));
		row_known.push_back(k);
		row_rsp.push_back(r);
		cmd_valid <= 1'b0;
	endtask

	initial begin
		rsp_t r;
		logic [31:0] v;
		cmd_valid = 1'b0;
		cmd = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		done_send = 1'b0;
		mir_head = NIL; mir_tail = NIL; mir_cur = NIL;
		for (int i = 0; i < NODES; i++) begin
			mir_used[i] = 1'b0; mir_val[i] = '0; mir_left[i] = NIL; mir_right[i] = NIL;
		end

		// empty list reads fail
		r = '0; r.error = 1'b1;
		add_row(OP_RD_FIRST, 0, 1, r);
		add_row(OP_RD_LAST, 0, 1, r);
		add_row(OP_RD_ACTIVE, 0, 1, r);
		r = '0;
		add_row(OP_DEL_FIRST, 0, 1, r);
		add_row(OP_GO_FIRST, 0, 1, r);
		add_row(OP_NEXT, 0, 1, r);
		add_row(OP_INS_AFTER, 32'h1234, 1, r);
		add_row(OP_INS_FIRST, 32'h7fffffff, 1, r);
		add_row(OP_INS_LAST, 32'h80000000, 1, r);
		add_row(OP_INS_LAST, 32'hffffffff);
		r = '0; r.read_value = 32'h7fffffff;
		add_row(OP_RD_FIRST, 0, 1, r);
		r = '0; r.read_value = 32'hffffffff;
		add_row(OP_RD_LAST, 0, 1, r);
		add_row(OP_GO_FIRST, 0);
		add_row(OP_DEL_BEFORE, 0);
		add_row(OP_PREV, 0);
		add_row(OP_GO_LAST, 0);
		add_row(OP_DEL_AFTER, 0);
		add_row(OP_INS_BEFORE, 32'h00000000);
		add_row(OP_WR_ACTIVE, 32'h5a5aa5a5);
		add_row(OP_DEL_BEFORE, 0);
		add_row(OP_DEL_LAST, 0);
		add_row(OP_QUERY, 0);
		r = '0;
		add_row(op_t'(5'd31), 32'hffffffff, 1, r);
		add_row(OP_CLEAR, 0, 1, r);

		wait (arst_n);
		@(posedge clk);
		foreach (rows[i]) send_beat(rows[i].op, rows[i].val, rows[i].known, rows[i].res);
		// fill past the pool size so inserts hit the full case
		for (int i = 0; i < 18; i++) send_beat(OP_INS_LAST, $urandom(), 0, '0);
		send_beat(OP_GO_FIRST, 0, 0, '0);
		send_beat(OP_INS_AFTER, 32'h1, 0, '0);
		send_beat(OP_INS_BEFORE, 32'h2, 0, '0);
		// sender pause until every response is back
		while (pending_rsp.size() != 0) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 81; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 81; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			for (int i = 0; i < 120; i++) begin
				int d;
				op_t o;
				d = $urandom_range(99, 0);
				if (d < 3) o = OP_CLEAR;
				else if (d < 20) o = (list_len() < 12) ? OP_INS_LAST : OP_DEL_FIRST;
				else if (d < 30) o = (d < 25) ? OP_INS_AFTER : OP_INS_BEFORE;
				else if (d < 33) o = op_t'($urandom_range(31, 18));
				else o = op_t'($urandom_range(17, 1));
				v = $urandom();
				if (d % 7 == 0) v = (d & 1) ? 32'h80000000 : 32'h7fffffff;
				send_beat(o, v, 0, '0);
			end
		end
		done_send = 1'b1;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule

[filelist.f]
design/dll_pkg.sv
design/dll_alloc.sv
design/doubly_linked_list_cursor.sv
sim/doubly_linked_list_cursor_tb.sv
